[hw/rtl/disjoint_set_union_engine_macros.svh]
// ----------------------------------------------------------------------------
// disjoint set union engine assertion macros
// shared concurrent assertion forms, clocked on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef DISJOINT_SET_UNION_ENGINE_MACROS_SVH
`define DISJOINT_SET_UNION_ENGINE_MACROS_SVH

// same-cycle implication
`define DSUE_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DSUE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/dsue_pkg.sv]
// ----------------------------------------------------------------------------
// dsue_pkg
// shared widths, operation codes, datapath commands and status
// ----------------------------------------------------------------------------
`default_nettype none

package dsue_pkg;

   localparam int MAX_NODES  = 1024;
   localparam int NODE_W     = $clog2(MAX_NODES);
   localparam int SIZE_W     = NODE_W + 1;
   localparam int FUNC_W     = 3;
   localparam int REQ_BITS   = 2 * NODE_W + SIZE_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = 3 + 3 * SIZE_W + NODE_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [FUNC_W-1:0] FUNC_UNION = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SIZE  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_HIST  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_INIT  = 3'd4;

   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_CLR_START,
      CMD_CLR_STEP,
      CMD_CLR_END,
      CMD_FIND_A,
      CMD_FIND_B,
      CMD_WALK,
      CMD_COMPRESS,
      CMD_COMPARE,
      CMD_SIZE_A,
      CMD_SIZE_B,
      CMD_MERGE,
      CMD_H1_RD,
      CMD_H1_WR,
      CMD_H2_RD,
      CMD_H2_WR,
      CMD_H3_RD,
      CMD_H3_WR,
      CMD_READ_SIZE,
      CMD_TAKE_SIZE,
      CMD_READ_HIST,
      CMD_TAKE_HIST,
      CMD_EMIT
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              bad;
      logic              at_root;
      logic              comp_done;
      logic              same_root;
      logic              clr_last;
   } dp_status_type;

endpackage

`default_nettype wire

[hw/rtl/dsue_dp.sv]
// ----------------------------------------------------------------------------
// dsue_dp
// tables, walk registers and result registers of the union-find engine
// ----------------------------------------------------------------------------
`default_nettype none

`include "disjoint_set_union_engine_macros.svh"

module dsue_dp
   import dsue_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   input  wire logic [REQ_DATA_W-1:0] req_data,
   input  wire logic [FUNC_W-1:0]     req_func,
   input  wire logic [SIZE_W-1:0]     node_count,
   output dp_status_type              status,
   output logic [RSP_DATA_W-1:0]      rsp_data
);

   logic [NODE_W-1:0] parent_mem_ff [MAX_NODES];
   logic [SIZE_W-1:0] size_mem_ff   [MAX_NODES];
   logic [SIZE_W-1:0] hist_mem_ff   [MAX_NODES];

   logic [NODE_W-1:0] prd_ff;
   logic [SIZE_W-1:0] srd_ff, hrd_ff;

   logic [FUNC_W-1:0] func_ff;
   logic [NODE_W-1:0] a_ff, b_ff, cur_ff, node_ff, root_ff, ra_ff, rb_ff;
   logic [SIZE_W-1:0] sidx_ff, sa_ff, sb_ff, sk_ff, sj_ff, total_ff;
   logic              sel_b_ff, bad_ff, connected_ff, merged_ff;
   logic [SIZE_W-1:0] value_ff;
   logic [RSP_DATA_W-1:0] rsp_ff;

   logic [SIZE_W-1:0] active_ff, clr_idx_ff, comps_ff, bsize_ff;
   logic [NODE_W-1:0] broot_ff;

   logic [NODE_W-1:0] req_a, req_b;
   logic [SIZE_W-1:0] req_sidx, clamp_n;
   logic              a_bad, b_bad, load_bad;
   logic              keep_b;
   logic [NODE_W-1:0] keep, join_root;
   logic [SIZE_W-1:0] sk, sj, total;
   logic [SIZE_W-1:0] sk_m1, sj_m1, tot_m1, sidx_m1;
   logic              hist_ok;
   logic              at_root, comp_done;

   logic [NODE_W-1:0] p_raddr, s_raddr, h_raddr;
   logic              p_we, s_we, h_we;
   logic [NODE_W-1:0] p_waddr, s_waddr, h_waddr, p_wdata;
   logic [SIZE_W-1:0] s_wdata, h_wdata;

   assign req_a    = req_data[NODE_W-1:0];
   assign req_b    = req_data[2*NODE_W-1:NODE_W];
   assign req_sidx = req_data[REQ_BITS-1:2*NODE_W];

   assign a_bad = {1'b0, req_a} >= active_ff;
   assign b_bad = {1'b0, req_b} >= active_ff;
   assign load_bad = ((req_func == FUNC_UNION) || (req_func == FUNC_QUERY)) ? (a_bad | b_bad)
                   : (req_func == FUNC_SIZE) ? a_bad : 1'b0;

   assign clamp_n = (node_count == '0) ? SIZE_W'(1)
                  : (node_count > SIZE_W'(MAX_NODES)) ? SIZE_W'(MAX_NODES) : node_count;

   // union by size, tie keeps the first root
   assign keep_b    = sa_ff < sb_ff;
   assign keep      = keep_b ? rb_ff : ra_ff;
   assign join_root = keep_b ? ra_ff : rb_ff;
   assign sk        = keep_b ? sb_ff : sa_ff;
   assign sj        = keep_b ? sa_ff : sb_ff;
   assign total     = sa_ff + sb_ff;

   assign sk_m1   = sk_ff - SIZE_W'(1);
   assign sj_m1   = sj_ff - SIZE_W'(1);
   assign tot_m1  = total_ff - SIZE_W'(1);
   assign sidx_m1 = sidx_ff - SIZE_W'(1);
   assign hist_ok = (sidx_ff != '0) && (sidx_ff <= SIZE_W'(MAX_NODES));

   assign at_root   = prd_ff == cur_ff;
   assign comp_done = cur_ff == root_ff;

   always_comb begin
      p_raddr = cur_ff;
      s_raddr = ra_ff;
      h_raddr = sk_m1[NODE_W-1:0];
      unique case (cmd)
         CMD_FIND_A:    p_raddr = a_ff;
         CMD_FIND_B:    p_raddr = b_ff;
         CMD_WALK:      p_raddr = at_root ? node_ff : prd_ff;
         CMD_COMPRESS:  p_raddr = prd_ff;
         CMD_SIZE_A:    s_raddr = rb_ff;
         CMD_READ_SIZE: s_raddr = a_ff;
         CMD_H2_RD:     h_raddr = sj_m1[NODE_W-1:0];
         CMD_H3_RD:     h_raddr = tot_m1[NODE_W-1:0];
         CMD_READ_HIST: h_raddr = sidx_m1[NODE_W-1:0];
         default: ;
      endcase
   end

   always_comb begin
      p_we    = 1'b0;
      p_waddr = clr_idx_ff[NODE_W-1:0];
      p_wdata = clr_idx_ff[NODE_W-1:0];
      s_we    = 1'b0;
      s_waddr = clr_idx_ff[NODE_W-1:0];
      s_wdata = SIZE_W'(1);
      h_we    = 1'b0;
      h_waddr = clr_idx_ff[NODE_W-1:0];
      h_wdata = (clr_idx_ff == '0) ? active_ff : '0;
      unique case (cmd)
         CMD_CLR_STEP: begin
            p_we = 1'b1;
            s_we = 1'b1;
            h_we = 1'b1;
         end
         CMD_COMPRESS: begin
            p_we    = !comp_done;
            p_waddr = cur_ff;
            p_wdata = root_ff;
         end
         CMD_MERGE: begin
            p_we    = 1'b1;
            p_waddr = join_root;
            p_wdata = keep;
            s_we    = 1'b1;
            s_waddr = keep;
            s_wdata = total;
         end
         CMD_H1_WR: begin
            h_we    = 1'b1;
            h_waddr = sk_m1[NODE_W-1:0];
            h_wdata = hrd_ff - SIZE_W'(1);
         end
         CMD_H2_WR: begin
            h_we    = 1'b1;
            h_waddr = sj_m1[NODE_W-1:0];
            h_wdata = hrd_ff - SIZE_W'(1);
         end
         CMD_H3_WR: begin
            h_we    = 1'b1;
            h_waddr = tot_m1[NODE_W-1:0];
            h_wdata = hrd_ff + SIZE_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (p_we) begin
         parent_mem_ff[p_waddr] <= p_wdata;
      end
      prd_ff <= parent_mem_ff[p_raddr];
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         size_mem_ff[s_waddr] <= s_wdata;
      end
      srd_ff <= size_mem_ff[s_raddr];
   end

   always_ff @(posedge clock) begin
      if (h_we) begin
         hist_mem_ff[h_waddr] <= h_wdata;
      end
      hrd_ff <= hist_mem_ff[h_raddr];
   end

   // architectural scalars
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= SIZE_W'(MAX_NODES);
         clr_idx_ff <= '0;
         comps_ff   <= SIZE_W'(MAX_NODES);
         broot_ff   <= '0;
         bsize_ff   <= SIZE_W'(1);
      end else begin
         unique case (cmd)
            CMD_CLR_START: begin
               active_ff  <= clamp_n;
               clr_idx_ff <= '0;
            end
            CMD_CLR_STEP: clr_idx_ff <= clr_idx_ff + SIZE_W'(1);
            CMD_CLR_END: begin
               comps_ff <= active_ff;
               broot_ff <= '0;
               bsize_ff <= SIZE_W'(1);
            end
            CMD_MERGE: begin
               comps_ff <= comps_ff - SIZE_W'(1);
               if (total > bsize_ff) begin
                  broot_ff <= keep;
                  bsize_ff <= total;
               end
            end
            default: ;
         endcase
      end
   end

   // per-transaction working registers
   always_ff @(posedge clock) begin
      unique case (cmd)
         CMD_LOAD: begin
            func_ff      <= req_func;
            a_ff         <= req_a;
            b_ff         <= req_b;
            sidx_ff      <= req_sidx;
            bad_ff       <= load_bad;
            connected_ff <= 1'b0;
            merged_ff    <= 1'b0;
            value_ff     <= '0;
         end
         CMD_FIND_A: begin
            cur_ff   <= a_ff;
            node_ff  <= a_ff;
            sel_b_ff <= 1'b0;
         end
         CMD_FIND_B: begin
            cur_ff   <= b_ff;
            node_ff  <= b_ff;
            sel_b_ff <= 1'b1;
         end
         CMD_WALK: begin
            if (at_root) begin
               root_ff <= cur_ff;
               cur_ff  <= node_ff;
            end else begin
               cur_ff <= prd_ff;
            end
         end
         CMD_COMPRESS: begin
            if (comp_done) begin
               if (sel_b_ff) begin
                  rb_ff <= root_ff;
               end else begin
                  ra_ff <= root_ff;
               end
            end else begin
               cur_ff <= prd_ff;
            end
         end
         CMD_COMPARE:   connected_ff <= ra_ff == rb_ff;
         CMD_SIZE_A:    sa_ff <= srd_ff;
         CMD_SIZE_B:    sb_ff <= srd_ff;
         CMD_MERGE: begin
            sk_ff     <= sk;
            sj_ff     <= sj;
            total_ff  <= total;
            merged_ff <= 1'b1;
         end
         CMD_TAKE_SIZE: value_ff <= srd_ff;
         CMD_TAKE_HIST: value_ff <= hist_ok ? hrd_ff : '0;
         CMD_EMIT: begin
            rsp_ff <= {{(RSP_DATA_W-RSP_BITS){1'b0}}, bad_ff, bsize_ff, broot_ff, comps_ff,
                       value_ff, merged_ff, connected_ff};
         end
         default: ;
      endcase
   end

   assign status.func      = func_ff;
   assign status.bad       = bad_ff;
   assign status.at_root   = at_root;
   assign status.comp_done = comp_done;
   assign status.same_root = ra_ff == rb_ff;
   assign status.clr_last  = clr_idx_ff == SIZE_W'(MAX_NODES - 1);

   assign rsp_data = rsp_ff;

   `DSUE_ASSERT_NEXT(a_merge_drops_count, cmd == CMD_MERGE, comps_ff == $past(comps_ff) - SIZE_W'(1), "merge did not drop component count")
   `DSUE_ASSERT_IMPL(a_largest_nonzero, 1'b1, bsize_ff != '0, "largest size is zero")

endmodule

`default_nettype wire

[hw/rtl/dsue_ctrl.sv]
// ----------------------------------------------------------------------------
// dsue_ctrl
// sequencer for clearing, root walks, compression, merge and reads
// ----------------------------------------------------------------------------
`default_nettype none

`include "disjoint_set_union_engine_macros.svh"

module dsue_ctrl
   import dsue_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire dp_status_type status,
   output cmd_type            cmd
);

   typedef enum logic [4:0] {
      ST_CLR_START, ST_CLR, ST_CLR_END, ST_IDLE, ST_DISPATCH,
      ST_WALK, ST_COMP, ST_FIND_B, ST_COMPARE,
      ST_SIZE_A, ST_SIZE_B, ST_MERGE,
      ST_H1R, ST_H1W, ST_H2R, ST_H2W, ST_H3R, ST_H3W,
      ST_TSIZE, ST_THIST, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      second_ff, second_in;
   logic      init_ff, init_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      second_in    = second_ff;
      init_in      = init_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd          = CMD_NOP;
      unique case (state_ff)
         ST_CLR_START: begin
            cmd      = CMD_CLR_START;
            state_in = ST_CLR;
         end
         ST_CLR: begin
            cmd = CMD_CLR_STEP;
            if (status.clr_last) state_in = ST_CLR_END;
         end
         ST_CLR_END: begin
            cmd      = CMD_CLR_END;
            state_in = init_ff ? ST_DONE : ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd       = CMD_LOAD;
               second_in = 1'b0;
               init_in   = 1'b0;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.func)
               FUNC_UNION, FUNC_QUERY: begin
                  if (status.bad) begin
                     state_in = ST_DONE;
                  end else begin
                     cmd      = CMD_FIND_A;
                     state_in = ST_WALK;
                  end
               end
               FUNC_SIZE: begin
                  if (status.bad) begin
                     state_in = ST_DONE;
                  end else begin
                     cmd      = CMD_READ_SIZE;
                     state_in = ST_TSIZE;
                  end
               end
               FUNC_HIST: begin
                  cmd      = CMD_READ_HIST;
                  state_in = ST_THIST;
               end
               FUNC_INIT: begin
                  cmd      = CMD_CLR_START;
                  init_in  = 1'b1;
                  state_in = ST_CLR;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_WALK: begin
            cmd = CMD_WALK;
            if (status.at_root) state_in = ST_COMP;
         end
         ST_COMP: begin
            cmd = CMD_COMPRESS;
            if (status.comp_done) begin
               second_in = 1'b1;
               state_in  = second_ff ? ST_COMPARE : ST_FIND_B;
            end
         end
         ST_FIND_B: begin
            cmd      = CMD_FIND_B;
            state_in = ST_WALK;
         end
         ST_COMPARE: begin
            cmd      = CMD_COMPARE;
            state_in = (status.same_root || (status.func != FUNC_UNION)) ? ST_DONE : ST_SIZE_A;
         end
         ST_SIZE_A: begin
            cmd      = CMD_SIZE_A;
            state_in = ST_SIZE_B;
         end
         ST_SIZE_B: begin
            cmd      = CMD_SIZE_B;
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            cmd      = CMD_MERGE;
            state_in = ST_H1R;
         end
         ST_H1R: begin
            cmd      = CMD_H1_RD;
            state_in = ST_H1W;
         end
         ST_H1W: begin
            cmd      = CMD_H1_WR;
            state_in = ST_H2R;
         end
         ST_H2R: begin
            cmd      = CMD_H2_RD;
            state_in = ST_H2W;
         end
         ST_H2W: begin
            cmd      = CMD_H2_WR;
            state_in = ST_H3R;
         end
         ST_H3R: begin
            cmd      = CMD_H3_RD;
            state_in = ST_H3W;
         end
         ST_H3W: begin
            cmd      = CMD_H3_WR;
            state_in = ST_DONE;
         end
         ST_TSIZE: begin
            cmd      = CMD_TAKE_SIZE;
            state_in = ST_DONE;
         end
         ST_THIST: begin
            cmd      = CMD_TAKE_HIST;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd          = CMD_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR_START;
         second_ff    <= 1'b0;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;

   `DSUE_ASSERT_NEXT(a_sweep_runs, (state_ff == ST_CLR) && !status.clr_last, state_ff == ST_CLR, "clearing pass left early")
   `DSUE_ASSERT_IMPL(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE, "response raised outside done")

endmodule

`default_nettype wire

[hw/rtl/disjoint_set_union_engine.sv]
// ----------------------------------------------------------------------------
// disjoint_set_union_engine
// union-find over up to 1024 nodes: union by size, full path compression,
// size histogram, component count and largest component tracking
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            contents
//   req_      in         req_tvalid/tready    node_a, node_b, size_index; tuser func
//   rsp_      out        rsp_tvalid/tready    one result per request transaction
//   csr_      in         csr_valid/ready      node_count, used at next initialize
//
// one transaction at a time, sequenced through the parent table
// reset starts a clearing pass of all three tables, req_tready low
// the response register lets the next request in while a result waits
//
`default_nettype none

module disjoint_set_union_engine
   import dsue_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request: node_a [9:0], node_b [19:10], size_index [30:20], zero pad
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // request kind: func [2:0]
   input  wire logic [FUNC_W-1:0]     req_tuser,
   // result: connected [0], merged [1], value [12:2], component_count [23:13],
   // largest_root [33:24], largest_size [44:34], bad_index [45], zero pad
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // configuration: node_count
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [SIZE_W-1:0]     csr_data
);

   logic [SIZE_W-1:0] node_count_ff;
   cmd_type           cmd;
   dp_status_type     status;

   // node count register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= SIZE_W'(MAX_NODES);
      end else if (csr_valid) begin
         node_count_ff <= csr_data;
      end
   end

   // sequencer
   dsue_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // tables and working registers
   dsue_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_tdata),
      .req_func   (req_tuser),
      .node_count (node_count_ff),
      .status     (status),
      .rsp_data   (rsp_tdata)
   );

endmodule

`default_nettype wire

[test/disjoint_set_union_engine_checker.sv]
// ----------------------------------------------------------------------------
// disjoint_set_union_engine_checker
// watches the request, result and csr channels, keeps its own union-find
// state and compares every result transaction field by field
// ----------------------------------------------------------------------------
`default_nettype none

module disjoint_set_union_engine_checker
   import dsue_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [FUNC_W-1:0]     req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [SIZE_W-1:0]     csr_data,
   output int                         fail_count,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AWAIT_DEPTH = 16;

   typedef struct packed {
      logic              bad_index;
      logic [SIZE_W-1:0] largest_size;
      logic [NODE_W-1:0] largest_root;
      logic [SIZE_W-1:0] component_count;
      logic [SIZE_W-1:0] value;
      logic              merged;
      logic              connected;
   } dsu_result_type;

   logic [NODE_W-1:0] parent [MAX_NODES];
   logic [SIZE_W-1:0] comp_size [MAX_NODES];
   logic [SIZE_W-1:0] size_count [MAX_NODES];
   logic [SIZE_W-1:0] components, top_size, nodes_set, nodes_live;
   logic [NODE_W-1:0] top_root;
   dsu_result_type    awaited [AWAIT_DEPTH];
   int                wr_count = 0;
   int                rd_count = 0;

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic void clear_forest();
      int n;
      n = nodes_set;
      if (n == 0) n = 1;
      if (n > MAX_NODES) n = MAX_NODES;
      nodes_live = SIZE_W'(n);
      for (int i = 0; i < MAX_NODES; i++) begin
         parent[i] = NODE_W'(i);
         comp_size[i] = SIZE_W'(1);
         size_count[i] = '0;
      end
      size_count[0] = SIZE_W'(n);
      components = SIZE_W'(n);
      top_root = '0;
      top_size = SIZE_W'(1);
   endfunction

   // walk to the root, then point the whole path at it
   function automatic int root_of(input int node);
      int r, cur, nxt;
      r = node;
      while (parent[r] != r) r = parent[r];
      cur = node;
      while (cur != r) begin
         nxt = parent[cur];
         parent[cur] = NODE_W'(r);
         cur = nxt;
      end
      return r;
   endfunction

   function automatic dsu_result_type apply_op(input logic [FUNC_W-1:0] op,
                                               input int a, input int b,
                                               input int sidx);
      dsu_result_type res;
      int ra, rb, keep, join_root, total;
      res = '0;
      if (op == FUNC_UNION || op == FUNC_QUERY) begin
         if (a >= nodes_live || b >= nodes_live) res.bad_index = 1'b1;
         else begin
            ra = root_of(a);
            rb = root_of(b);
            if (ra == rb) res.connected = 1'b1;
            else if (op == FUNC_UNION) begin
               keep = ra;
               join_root = rb;
               if (comp_size[ra] < comp_size[rb]) begin
                  keep = rb;
                  join_root = ra;
               end
               total = comp_size[keep] + comp_size[join_root];
               parent[join_root] = NODE_W'(keep);
               size_count[comp_size[keep]-1]--;
               size_count[comp_size[join_root]-1]--;
               size_count[total-1]++;
               comp_size[keep] = SIZE_W'(total);
               if (total > top_size) begin
                  top_root = NODE_W'(keep);
                  top_size = SIZE_W'(total);
               end
               components--;
               res.merged = 1'b1;
            end
         end
      end else if (op == FUNC_SIZE) begin
         if (a >= nodes_live) res.bad_index = 1'b1;
         else res.value = comp_size[a];
      end else if (op == FUNC_HIST) begin
         if (sidx >= 1 && sidx <= MAX_NODES) res.value = size_count[sidx-1];
      end else if (op == FUNC_INIT) begin
         clear_forest();
      end
      res.component_count = components;
      res.largest_root = top_root;
      res.largest_size = top_size;
      return res;
   endfunction

   initial begin
      fail_count = 0;
      nodes_set = SIZE_W'(MAX_NODES);
      clear_forest();
   end

   assign pending = wr_count - rd_count;

   always @(posedge clock) begin
      dsu_result_type got, want;
      if (!reset) begin
         if (csr_valid && csr_ready) nodes_set = csr_data;
         if (req_tvalid && req_tready) begin
            awaited[wr_count % AWAIT_DEPTH] = apply_op(req_tuser, req_tdata[NODE_W-1:0],
                                               req_tdata[2*NODE_W-1:NODE_W],
                                               req_tdata[2*NODE_W+SIZE_W-1:2*NODE_W]);
            wr_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_BITS-1:0];
            if (wr_count == rd_count) report("result transaction with none expected");
            else begin
               want = awaited[rd_count % AWAIT_DEPTH];
               rd_count++;
               if (got.connected !== want.connected)
                  report($sformatf("connected %0d want %0d", got.connected, want.connected));
               if (got.merged !== want.merged)
                  report($sformatf("merged %0d want %0d", got.merged, want.merged));
               if (got.value !== want.value)
                  report($sformatf("value %0d want %0d", got.value, want.value));
               if (got.component_count !== want.component_count)
                  report($sformatf("component_count %0d want %0d",
                                   got.component_count, want.component_count));
               if (got.largest_root !== want.largest_root)
                  report($sformatf("largest_root %0d want %0d",
                                   got.largest_root, want.largest_root));
               if (got.largest_size !== want.largest_size)
                  report($sformatf("largest_size %0d want %0d",
                                   got.largest_size, want.largest_size));
               if (got.bad_index !== want.bad_index)
                  report($sformatf("bad_index %0d want %0d",
                                   got.bad_index, want.bad_index));
            end
         end
      end
   end

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// drives random union-find operations with random stalls on both channels,
// several node counts, and gives the verdict from the checker's count
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
   import dsue_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // unused function codes
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

   logic                  clock, reset;
   logic                  req_tvalid, req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [FUNC_W-1:0]     req_tuser;
   logic                  rsp_tvalid, rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid, csr_ready;
   logic [SIZE_W-1:0]     csr_data;
   int                    fail_count, pending;
   int                    span;   // node range the random ops aim at

   disjoint_set_union_engine uut (.*);
   disjoint_set_union_engine_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // a short pause, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // one request transaction; valid drops only between gaps
   task automatic send_op(input logic [FUNC_W-1:0] op, input int a, input int b,
                          input int sidx);
      int g;
      logic [REQ_DATA_W-1:0] word;
      g = gap_len();
      word = '0;
      word[NODE_W-1:0] = NODE_W'(a);
      word[2*NODE_W-1:NODE_W] = NODE_W'(b);
      word[2*NODE_W+SIZE_W-1:2*NODE_W] = SIZE_W'(sidx);
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // pause until every result has drained, then let the engine settle
   task automatic drain();
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic set_nodes(input int n);
      drain();
      csr_valid <= 1;
      csr_data  <= SIZE_W'(n);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
      send_op(FUNC_INIT, 0, 0, 1);
      span = (n == 0) ? 1 : (n > MAX_NODES ? MAX_NODES : n);
   endtask

   task automatic random_op();
      int r, a, b;
      r = $urandom_range(0, 99);
      // mostly in-range indexes, some anywhere in the field
      a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, span - 1);
      b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, span - 1);
      if (r < 45) send_op(FUNC_UNION, a, b, $urandom_range(0, 2047));
      else if (r < 65) send_op(FUNC_QUERY, a, b, $urandom_range(0, 2047));
      else if (r < 80) send_op(FUNC_SIZE, a, b, $urandom_range(0, 2047));
      else if (r < 95)
         send_op(FUNC_HIST, a, b, ($urandom_range(0, 3) == 0) ?
                 $urandom_range(0, 2047) : $urandom_range(1, 8));
      else if (r < 97)
         send_op(FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)), a, b,
                 $urandom_range(0, 2047));
      else send_op(FUNC_INIT, a, b, $urandom_range(0, 2047));
   endtask

   // result side stalls at random, with a calm stretch in the middle
   initial begin
      rsp_tready = 0;
      @(negedge clock);
      forever begin
         rsp_tready <= 1;
         @(negedge clock);
         if ($realtime > 200000 && $realtime < 300000) continue;
         if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 0;
            repeat (gap_len() + 1) @(negedge clock);
         end
      end
   end

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = FUNC_UNION;
      csr_valid = 0;
      csr_data = '0;
      span = MAX_NODES;
      repeat (8) @(negedge clock);
      reset <= 0;

      // directed: reset state, field extremes, every op and special case
      send_op(FUNC_HIST, 0, 0, 1);
      send_op(FUNC_HIST, 0, 0, 0);
      send_op(FUNC_HIST, 0, 0, 1024);
      send_op(FUNC_HIST, 0, 0, 2047);
      send_op(FUNC_UNION, 0, 1023, 0);
      send_op(FUNC_UNION, 1023, 0, 0);
      send_op(FUNC_QUERY, 0, 1023, 0);
      send_op(FUNC_SIZE, 1023, 0, 0);
      send_op(FUNC_UNION, 5, 6, 0);
      send_op(FUNC_UNION, 6, 0, 0);
      send_op(FUNC_HIST, 0, 0, 4);
      send_op(FUNC_SPARE_HI, 1023, 1023, 2047);
      send_op(FUNC_SPARE_LO, 0, 0, 0);
      set_nodes(0);
      send_op(FUNC_UNION, 0, 1, 0);
      send_op(FUNC_SIZE, 0, 0, 0);
      set_nodes(2047);
      send_op(FUNC_SIZE, 1023, 0, 0);
      set_nodes(3);
      send_op(FUNC_QUERY, 3, 0, 0);
      send_op(FUNC_UNION, 0, 2, 0);
      send_op(FUNC_SIZE, 2, 0, 0);

      // random phases over several node counts
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: set_nodes($urandom_range(2, 16));
            1: set_nodes($urandom_range(17, 64));
            2: set_nodes(1024);
            default: set_nodes(1);
         endcase
         for (int k = 0; k < 200; k++) random_op();
      end
      drain();
      if (fail_count == 0)
         $display("disjoint_set_union_engine regression: pass");
      else
         $display("disjoint_set_union_engine regression: fail");
      $finish;
   end

   initial begin
      #100ms;
      $display("disjoint_set_union_engine regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
